// ----- hw/rtl/apsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// All-pairs shortest path package
// Shared types, sizes and the microprogram of the sequencer.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int NODE_BITS = 6;
    localparam int MAX_NODES = 1 << NODE_BITS;
    localparam int CNT_BITS  = NODE_BITS + 1;
    localparam int ADDR_BITS = 2 * NODE_BITS;
    localparam int DIST_BITS = 40;
    localparam int WGT_BITS  = 32;

    localparam logic [DIST_BITS-1:0] DIST_INF = '1;
    localparam logic [CNT_BITS-1:0]  NODE_COUNT_RESET = CNT_BITS'(MAX_NODES);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef struct packed {
        t_action                action;
        logic [NODE_BITS-1:0]   node_from;
        logic [NODE_BITS-1:0]   node_to;
        logic [WGT_BITS-1:0]    edge_weight;
    } t_req;

    typedef struct packed {
        logic [DIST_BITS-1:0]   distance;
        logic                   reachable;
    } t_rsp;

    // Microprogram addresses.
    typedef enum logic [3:0] {
        UP_IDLE   = 4'd0,
        UP_CLR    = 4'd1,
        UP_UV     = 4'd2,
        UP_VU     = 4'd3,
        UP_RUN    = 4'd4,
        UP_LEFT   = 4'd5,
        UP_LEFT_W = 4'd6,
        UP_CELL   = 4'd7,
        UP_RELAX  = 4'd8,
        UP_ROW    = 4'd9,
        UP_VIA    = 4'd10,
        UP_QRD    = 4'd11,
        UP_QOUT   = 4'd12
    } t_upc;

    // Source of the address on read port A.
    typedef enum logic [1:0] {
        ASEL_VIA_COL = 2'd0,
        ASEL_ROW_VIA = 2'd1,
        ASEL_QUERY   = 2'd2
    } t_asel;

    typedef enum logic [2:0] {
        WR_NONE  = 3'd0,
        WR_CLEAR = 3'd1,
        WR_UV    = 3'd2,
        WR_VU    = 3'd3,
        WR_RELAX = 3'd4
    } t_wr_op;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_CLR_MORE = 3'd2,
        C_N_ZERO   = 3'd3,
        C_LEFT_INF = 3'd4,
        C_COL_MORE = 3'd5,
        C_ROW_MORE = 3'd6,
        C_VIA_MORE = 3'd7
    } t_cond;

    typedef struct packed {
        t_asel  a_sel;
        t_wr_op wr;
        logic   left_ld;
        logic   clr_inc;
        logic   col_inc;
        logic   row_inc;
        logic   via_inc;
        logic   emit;
        t_cond  cond;
        t_upc   jmp;
        t_upc   next;
    } t_uop;

    // Status flags returned by the datapath to the sequencer.
    typedef struct packed {
        logic clr_last;
        logic n_zero;
        logic left_inf;
        logic col_last;
        logic row_last;
        logic via_last;
    } t_stat;

    localparam t_uop UOP_NOP = '{
        a_sel:   ASEL_VIA_COL,
        wr:      WR_NONE,
        left_ld: 1'b0,
        clr_inc: 1'b0,
        col_inc: 1'b0,
        row_inc: 1'b0,
        via_inc: 1'b0,
        emit:    1'b0,
        cond:    C_NEVER,
        jmp:     UP_IDLE,
        next:    UP_IDLE
    };

    // Control store. When the condition holds the step goes to jmp, else to next.
    function automatic t_uop uop_rom(input t_upc pc);
        t_uop u;
        u = UOP_NOP;
        case (pc)
            UP_IDLE: begin
                u.cond = C_ALWAYS;
                u.jmp  = UP_IDLE;
            end
            UP_CLR: begin
                u.wr      = WR_CLEAR;
                u.clr_inc = 1'b1;
                u.cond    = C_CLR_MORE;
                u.jmp     = UP_CLR;
                u.next    = UP_IDLE;
            end
            UP_UV: begin
                u.wr   = WR_UV;
                u.next = UP_VU;
            end
            UP_VU: begin
                u.wr   = WR_VU;
                u.next = UP_IDLE;
            end
            UP_RUN: begin
                u.cond = C_N_ZERO;
                u.jmp  = UP_IDLE;
                u.next = UP_LEFT;
            end
            UP_LEFT: begin
                u.a_sel = ASEL_ROW_VIA;
                u.next  = UP_LEFT_W;
            end
            UP_LEFT_W: begin
                u.left_ld = 1'b1;
                u.cond    = C_LEFT_INF;
                u.jmp     = UP_ROW;
                u.next    = UP_CELL;
            end
            UP_CELL: begin
                u.a_sel = ASEL_VIA_COL;
                u.next  = UP_RELAX;
            end
            UP_RELAX: begin
                u.wr      = WR_RELAX;
                u.col_inc = 1'b1;
                u.cond    = C_COL_MORE;
                u.jmp     = UP_CELL;
                u.next    = UP_ROW;
            end
            UP_ROW: begin
                u.row_inc = 1'b1;
                u.cond    = C_ROW_MORE;
                u.jmp     = UP_LEFT;
                u.next    = UP_VIA;
            end
            UP_VIA: begin
                u.via_inc = 1'b1;
                u.cond    = C_VIA_MORE;
                u.jmp     = UP_LEFT;
                u.next    = UP_IDLE;
            end
            UP_QRD: begin
                u.a_sel = ASEL_QUERY;
                u.next  = UP_QOUT;
            end
            UP_QOUT: begin
                u.emit = 1'b1;
                u.next = UP_IDLE;
            end
            default: begin
                u.next = UP_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

// ----- hw/rtl/apsp_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// All-pairs shortest path datapath
// Distance memory, loop counters and the saturating relaxation unit.
// ----------------------------------------------------------------------------
module apsp_dp import apsp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_uop                 i_uop,
    input  t_req                 i_req,
    input  logic [CNT_BITS-1:0]  i_node_count,
    output t_stat                o_stat,
    output logic [DIST_BITS-1:0] o_rd_dist
);

    logic [DIST_BITS-1:0] r_mem [MAX_NODES*MAX_NODES];
    logic [DIST_BITS-1:0] r_rd_a;
    logic [DIST_BITS-1:0] r_rd_b;
    logic [DIST_BITS-1:0] r_left;
    logic [ADDR_BITS-1:0] r_clr;
    logic [NODE_BITS-1:0] r_via;
    logic [NODE_BITS-1:0] r_row;
    logic [NODE_BITS-1:0] r_col;

    logic [CNT_BITS-1:0]  n_eff;
    logic [CNT_BITS-1:0]  n_last;
    logic                 col_last;
    logic                 row_last;
    logic                 via_last;
    logic [ADDR_BITS-1:0] addr_a;
    logic [ADDR_BITS-1:0] addr_b;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [DIST_BITS-1:0] wr_data;
    logic                 wr_en;
    logic [DIST_BITS:0]   sum;
    logic [DIST_BITS-1:0] cand;
    logic [DIST_BITS-1:0] weight;

    // Node counts above the matrix size are treated as the full matrix.
    assign n_eff  = (i_node_count > CNT_BITS'(MAX_NODES)) ? CNT_BITS'(MAX_NODES)
                                                          : i_node_count;
    assign n_last = n_eff - CNT_BITS'(1);

    assign col_last = ({1'b0, r_col} == n_last);
    assign row_last = ({1'b0, r_row} == n_last);
    assign via_last = ({1'b0, r_via} == n_last);

    always_comb begin
        case (i_uop.a_sel)
            ASEL_ROW_VIA: addr_a = {r_row, r_via};
            ASEL_QUERY:   addr_a = {i_req.node_from, i_req.node_to};
            default:      addr_a = {r_via, r_col};
        endcase
    end
    assign addr_b = {r_row, r_col};

    // The weight field is narrower than the infinity code, so it never saturates.
    assign weight = {{(DIST_BITS-WGT_BITS){1'b0}}, i_req.edge_weight};

    // Left leg is known finite here; the sum saturates just below infinity.
    assign sum  = {1'b0, r_left} + {1'b0, r_rd_a};
    assign cand = (sum >= {1'b0, DIST_INF}) ? (DIST_INF - DIST_BITS'(1))
                                            : sum[DIST_BITS-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_b;
        wr_data = cand;
        case (i_uop.wr)
            WR_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = (r_clr[ADDR_BITS-1:NODE_BITS] == r_clr[NODE_BITS-1:0])
                          ? '0 : DIST_INF;
            end
            WR_UV: begin
                wr_en   = 1'b1;
                wr_addr = {i_req.node_from, i_req.node_to};
                wr_data = weight;
            end
            WR_VU: begin
                wr_en   = 1'b1;
                wr_addr = {i_req.node_to, i_req.node_from};
                wr_data = weight;
            end
            WR_RELAX: begin
                wr_en = (r_rd_a != DIST_INF) && (cand < r_rd_b);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
        if (i_uop.left_ld) begin
            r_left <= r_rd_a;
        end
    end

    // Loop counters wrap to zero after their last value, so a finished run
    // leaves them all at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_via <= '0;
            r_row <= '0;
            r_col <= '0;
        end else begin
            if (i_uop.clr_inc) begin
                r_clr <= r_clr + ADDR_BITS'(1);
            end
            if (i_uop.col_inc) begin
                r_col <= col_last ? '0 : r_col + NODE_BITS'(1);
            end
            if (i_uop.row_inc) begin
                r_row <= row_last ? '0 : r_row + NODE_BITS'(1);
            end
            if (i_uop.via_inc) begin
                r_via <= via_last ? '0 : r_via + NODE_BITS'(1);
            end
        end
    end

    assign o_stat.clr_last = &r_clr;
    assign o_stat.n_zero   = (n_eff == '0);
    assign o_stat.left_inf = (r_rd_a == DIST_INF);
    assign o_stat.col_last = col_last;
    assign o_stat.row_last = row_last;
    assign o_stat.via_last = via_last;
    assign o_rd_dist       = r_rd_a;

endmodule

// ----- hw/rtl/all_pairs_shortest_path_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// All-pairs shortest path engine
// Floyd-Warshall over a 64 by 64 distance memory, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Request steps: an edge writes UV then VU; a query reads in QRD and emits in QOUT;
//   clear writes one matrix entry per cycle; run takes a CELL and a RELAX step per
//   cell, and only LEFT, LEFT_W and ROW for a row whose left leg is infinite.
// A new request is taken only while not busy; results cannot be stalled.
// Reset clears the sequencer, loop counters and result strobe and sets node_count
// to 64; the distance memory holds no defined value until a clear request.
module all_pairs_shortest_path_top import apsp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  t_req                i_req,
    output logic                busy,
    output logic                o_valid,
    output t_rsp                o_rsp,
    input  logic                i_cfg_we,
    input  logic [CNT_BITS-1:0] i_cfg_wdata
);

    // Sequencer state: the step counter, the latched request and the
    // node count register.
    t_upc                 r_upc;
    t_upc                 n_upc;
    t_req                 r_req;
    logic [CNT_BITS-1:0]  r_node_count;
    logic                 r_valid;
    t_rsp                 r_rsp;

    t_uop                 uop;
    t_stat                stat;
    logic                 cond_true;
    logic                 accept;
    t_upc                 entry;
    logic [DIST_BITS-1:0] rd_dist;

    // The datapath holds the distance memory and all loop counters.
    apsp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uop        (uop),
        .i_req        (r_req),
        .i_node_count (r_node_count),
        .o_stat       (stat),
        .o_rd_dist    (rd_dist)
    );

    // The control word of the current step comes straight from the control store.
    assign uop    = uop_rom(r_upc);
    assign busy   = (r_upc != UP_IDLE);
    assign accept = start && !busy;

    // Each request type has its own entry point in the microprogram.
    always_comb begin
        case (i_req.action)
            ACT_CLEAR: entry = UP_CLR;
            ACT_EDGE:  entry = UP_UV;
            ACT_RUN:   entry = UP_RUN;
            ACT_QUERY: entry = UP_QRD;
            default:   entry = UP_IDLE;
        endcase
    end

    // Branch conditions test the datapath flags as they stand before this
    // step's counter updates.
    always_comb begin
        case (uop.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_CLR_MORE: cond_true = !stat.clr_last;
            C_N_ZERO:   cond_true = stat.n_zero;
            C_LEFT_INF: cond_true = stat.left_inf;
            C_COL_MORE: cond_true = !stat.col_last;
            C_ROW_MORE: cond_true = !stat.row_last;
            C_VIA_MORE: cond_true = !stat.via_last;
            default:    cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (accept) begin
            n_upc = entry;
        end else if (cond_true) begin
            n_upc = uop.jmp;
        end else begin
            n_upc = uop.next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc        <= UP_IDLE;
            r_node_count <= NODE_COUNT_RESET;
            r_valid      <= 1'b0;
        end else begin
            r_upc   <= n_upc;
            r_valid <= uop.emit;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
        end
    end

    // Request payload is held for the whole operation; the response is
    // registered, and o_valid is high for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (uop.emit) begin
            r_rsp.distance  <= rd_dist;
            r_rsp.reachable <= (rd_dist != DIST_INF);
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule
